// File: design/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// shared types and constants for the lidar sector steering block
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int RANGE_W    = 16;
    localparam int EDGE_W     = RANGE_W + 1;
    localparam int CFG_IDX_W  = 11;
    localparam int SPEED_W    = 8;
    localparam int CMD_W      = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_NEAR_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_THRESHOLD  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_START    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MIDDLE         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_END       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CRUISE_SPEED   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TURN_SPEED     = 3'd6;

    // drive command codes
    localparam logic [CMD_W-1:0] CMD_STOP          = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FORWARD       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TURN_LEFT     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TURN_RIGHT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FORWARD_LEFT  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_FORWARD_RIGHT = 3'd7;

    // edge range with no-return flag on top
    localparam logic [EDGE_W-1:0] EDGE_NO_RETURN = {1'b1, {RANGE_W{1'b0}}};

    typedef struct packed {
        logic [RANGE_W-1:0]   near_threshold_mm;
        logic [RANGE_W-1:0]   gap_threshold_mm;
        logic [CFG_IDX_W-1:0] right_start_index;
        logic [CFG_IDX_W-1:0] middle_index;
        logic [CFG_IDX_W-1:0] left_end_index;
        logic [SPEED_W-1:0]   cruise_speed;
        logic [SPEED_W-1:0]   turn_speed;
    } t_cfg;

    // summary of one finished scan, handed from front to back
    typedef struct packed {
        logic              right_obstacle;
        logic              left_obstacle;
        logic [EDGE_W-1:0] right_edge_range;
        logic [EDGE_W-1:0] left_edge_range;
    } t_scan_rec;

endpackage

// File: design/lss_front.sv
// ----------------------------------------------------------------------------
// lss_front
// per-sample classifier: index count, obstacle flags, edge capture
// ----------------------------------------------------------------------------
module lss_front #(
    parameter int MAX_SAMPLES = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lss_pkg::t_cfg                i_cfg,
    input  logic                         i_take,
    input  logic [lss_pkg::RANGE_W-1:0]  i_range_mm,
    input  logic                         i_no_return,
    input  logic                         i_scan_end,
    output logic                         o_push,
    output lss_pkg::t_scan_rec           o_rec
);

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CMP_W = (IDX_W > lss_pkg::CFG_IDX_W) ? IDX_W : lss_pkg::CFG_IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SAMPLES - 1);

    logic [IDX_W-1:0]           r_idx, n_idx;
    logic                       r_right_obs, n_right_obs;
    logic                       r_left_obs, n_left_obs;
    logic [lss_pkg::EDGE_W-1:0] r_right_edge, n_right_edge;
    logic [lss_pkg::EDGE_W-1:0] r_left_edge, n_left_edge;

    logic [CMP_W-1:0]           idx_c;
    logic                       in_window;
    logic                       hit;
    logic [lss_pkg::EDGE_W-1:0] sample_edge;

    assign idx_c     = CMP_W'(r_idx);
    assign in_window = (idx_c >= CMP_W'(i_cfg.right_start_index)) &&
                       (idx_c <= CMP_W'(i_cfg.left_end_index));
    assign hit       = in_window && !i_no_return && (i_range_mm < i_cfg.near_threshold_mm);
    assign sample_edge = i_no_return ? lss_pkg::EDGE_NO_RETURN : {1'b0, i_range_mm};

    always_comb begin
        n_right_obs  = r_right_obs;
        n_left_obs   = r_left_obs;
        n_right_edge = r_right_edge;
        n_left_edge  = r_left_edge;
        n_idx        = r_idx;
        if (i_take) begin
            if (hit) begin
                if (idx_c <= CMP_W'(i_cfg.middle_index)) begin
                    n_right_obs = 1'b1;
                end else begin
                    n_left_obs = 1'b1;
                end
            end
            if (idx_c == CMP_W'(i_cfg.right_start_index)) begin
                n_right_edge = sample_edge;
            end
            if (idx_c == CMP_W'(i_cfg.left_end_index)) begin
                n_left_edge = sample_edge;
            end
            n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        end
    end

    // summary includes the closing sample itself
    assign o_push = i_take && i_scan_end;
    assign o_rec  = '{right_obstacle:   n_right_obs,
                      left_obstacle:    n_left_obs,
                      right_edge_range: n_right_edge,
                      left_edge_range:  n_left_edge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_idx        <= '0;
            r_right_obs  <= 1'b0;
            r_left_obs   <= 1'b0;
            r_right_edge <= lss_pkg::EDGE_NO_RETURN;
            r_left_edge  <= lss_pkg::EDGE_NO_RETURN;
        end else begin
            r_idx        <= n_idx;
            r_right_obs  <= n_right_obs;
            r_left_obs   <= n_left_obs;
            r_right_edge <= n_right_edge;
            r_left_edge  <= n_left_edge;
        end
    end

endmodule

// File: design/lss_queue.sv
// ----------------------------------------------------------------------------
// lss_queue
// short queue of scan summaries between front and back
// ----------------------------------------------------------------------------
module lss_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  lss_pkg::t_scan_rec            i_rec,
    input  logic                          i_pop,
    output lss_pkg::t_scan_rec            o_rec,
    output logic [lss_pkg::QUEUE_AW:0]    o_count
);

    lss_pkg::t_scan_rec r_mem [lss_pkg::QUEUE_DEPTH];

    logic [lss_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [lss_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [lss_pkg::QUEUE_AW:0]   r_count, n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_rec   = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: design/lss_back.sv
// ----------------------------------------------------------------------------
// lss_back
// turns a scan summary into a drive command and wheel speeds
// ----------------------------------------------------------------------------
module lss_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lss_pkg::t_cfg                 i_cfg,
    input  logic                          i_rec_valid,
    input  lss_pkg::t_scan_rec            i_rec,
    output logic                          o_rec_pop,
    input  logic                          i_out_pop,
    output logic                          o_out_valid,
    output logic [lss_pkg::CMD_W-1:0]     o_command,
    output logic [lss_pkg::SPEED_W-1:0]   o_left_speed,
    output logic [lss_pkg::SPEED_W-1:0]   o_right_speed
);

    logic                          r_valid;
    logic [lss_pkg::CMD_W-1:0]     r_command, n_command;
    logic [lss_pkg::SPEED_W-1:0]   r_left_speed, n_left_speed;
    logic [lss_pkg::SPEED_W-1:0]   r_right_speed, n_right_speed;

    logic [lss_pkg::RANGE_W-1:0]   right_r;
    logic [lss_pkg::RANGE_W-1:0]   left_r;
    logic [lss_pkg::RANGE_W-1:0]   gap;
    logic                          edges_ok;

    assign right_r  = i_rec.right_edge_range[lss_pkg::RANGE_W-1:0];
    assign left_r   = i_rec.left_edge_range[lss_pkg::RANGE_W-1:0];
    assign edges_ok = !i_rec.right_edge_range[lss_pkg::RANGE_W] &&
                      !i_rec.left_edge_range[lss_pkg::RANGE_W];
    assign gap      = (left_r > right_r) ? (left_r - right_r) : (right_r - left_r);

    always_comb begin
        n_command = lss_pkg::CMD_FORWARD;
        if (i_rec.right_obstacle && i_rec.left_obstacle) begin
            n_command = lss_pkg::CMD_STOP;
        end else if (i_rec.right_obstacle) begin
            n_command = lss_pkg::CMD_TURN_LEFT;
        end else if (i_rec.left_obstacle) begin
            n_command = lss_pkg::CMD_TURN_RIGHT;
        end else if (edges_ok && (gap > i_cfg.gap_threshold_mm)) begin
            n_command = (right_r > left_r) ? lss_pkg::CMD_FORWARD_RIGHT
                                           : lss_pkg::CMD_FORWARD_LEFT;
        end
    end

    always_comb begin
        case (n_command)
            lss_pkg::CMD_STOP: begin
                n_left_speed  = '0;
                n_right_speed = '0;
            end
            lss_pkg::CMD_TURN_LEFT, lss_pkg::CMD_TURN_RIGHT: begin
                n_left_speed  = i_cfg.turn_speed;
                n_right_speed = i_cfg.turn_speed;
            end
            lss_pkg::CMD_FORWARD_LEFT: begin
                n_left_speed  = i_cfg.turn_speed;
                n_right_speed = i_cfg.cruise_speed;
            end
            lss_pkg::CMD_FORWARD_RIGHT: begin
                n_left_speed  = i_cfg.cruise_speed;
                n_right_speed = i_cfg.turn_speed;
            end
            default: begin
                n_left_speed  = i_cfg.cruise_speed;
                n_right_speed = i_cfg.cruise_speed;
            end
        endcase
    end

    // refill the output register when it is free or being drained
    assign o_rec_pop = i_rec_valid && (!r_valid || i_out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rec_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_command     <= n_command;
            r_left_speed  <= n_left_speed;
            r_right_speed <= n_right_speed;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_command     = r_command;
    assign o_left_speed  = r_left_speed;
    assign o_right_speed = r_right_speed;

endmodule

// File: design/lidar_sector_steering.sv
// ----------------------------------------------------------------------------
// lidar_sector_steering
// obstacle steering from a stream of lidar samples, one command per scan
// ----------------------------------------------------------------------------
// throughput: one sample per cycle; full rises only when the two-entry
//   summary queue is full because results are not being popped
// path: a scan-end sample's summary is written into the queue, then moved into the
//   output register once that register is free or being drained
// reset: synchronous active-low; config returns to defaults, scan state clears,
//   queue and output register empty; no clearing pass
// ----------------------------------------------------------------------------
module lidar_sector_steering #(
    parameter int MAX_SAMPLES = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // sample input, queue style
    input  logic                              push,
    output logic                              full,
    input  logic [lss_pkg::RANGE_W-1:0]       i_range_mm,
    input  logic                              i_no_return,
    input  logic                              i_scan_end,

    // command output, queue style
    output logic                              empty,
    input  logic                              pop,
    output logic [lss_pkg::CMD_W-1:0]         o_command,
    output logic [lss_pkg::SPEED_W-1:0]       o_left_speed,
    output logic [lss_pkg::SPEED_W-1:0]       o_right_speed,

    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lss_pkg::CFG_ADDR_W-1:0]    i_cfg_index,
    input  logic [lss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    lss_pkg::t_cfg                 r_cfg;
    lss_pkg::t_scan_rec            front_rec;
    lss_pkg::t_scan_rec            q_rec;
    logic                          front_push;
    logic                          take;
    logic                          q_pop;
    logic                          q_valid;
    logic [lss_pkg::QUEUE_AW:0]    q_count;
    logic                          out_valid;

    // ------------------------------------------------------------------------
    // configuration registers; writes are always taken
    // ------------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_threshold_mm <= 16'd1500;
            r_cfg.gap_threshold_mm  <= 16'd150;
            r_cfg.right_start_index <= 11'd481;
            r_cfg.middle_index      <= 11'd642;
            r_cfg.left_end_index    <= 11'd803;
            r_cfg.cruise_speed      <= 8'd150;
            r_cfg.turn_speed        <= 8'd130;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lss_pkg::REG_NEAR_THRESHOLD: r_cfg.near_threshold_mm <= i_cfg_data;
                lss_pkg::REG_GAP_THRESHOLD:  r_cfg.gap_threshold_mm  <= i_cfg_data;
                lss_pkg::REG_RIGHT_START:
                    r_cfg.right_start_index <= i_cfg_data[lss_pkg::CFG_IDX_W-1:0];
                lss_pkg::REG_MIDDLE:
                    r_cfg.middle_index <= i_cfg_data[lss_pkg::CFG_IDX_W-1:0];
                lss_pkg::REG_LEFT_END:
                    r_cfg.left_end_index <= i_cfg_data[lss_pkg::CFG_IDX_W-1:0];
                lss_pkg::REG_CRUISE_SPEED:
                    r_cfg.cruise_speed <= i_cfg_data[lss_pkg::SPEED_W-1:0];
                lss_pkg::REG_TURN_SPEED:
                    r_cfg.turn_speed <= i_cfg_data[lss_pkg::SPEED_W-1:0];
                default: begin
                    // writes to unused indexes are dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // front: classify every accepted sample transaction
    // ------------------------------------------------------------------------
    // full depends only on queue occupancy, so a waiting result never blocks
    // samples until two more scan summaries are stacked behind it
    assign full = (q_count == (lss_pkg::QUEUE_AW + 1)'(lss_pkg::QUEUE_DEPTH));
    assign take = push && !full;

    lss_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_take      (take),
        .i_range_mm  (i_range_mm),
        .i_no_return (i_no_return),
        .i_scan_end  (i_scan_end),
        .o_push      (front_push),
        .o_rec       (front_rec)
    );

    // ------------------------------------------------------------------------
    // summary queue between front and back
    // ------------------------------------------------------------------------
    lss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_rec   (front_rec),
        .i_pop   (q_pop),
        .o_rec   (q_rec),
        .o_count (q_count)
    );

    assign q_valid = (q_count != '0);

    // ------------------------------------------------------------------------
    // back: decision and output register
    // ------------------------------------------------------------------------
    lss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_rec_valid   (q_valid),
        .i_rec         (q_rec),
        .o_rec_pop     (q_pop),
        .i_out_pop     (pop),
        .o_out_valid   (out_valid),
        .o_command     (o_command),
        .o_left_speed  (o_left_speed),
        .o_right_speed (o_right_speed)
    );

    assign empty = !out_valid;

`ifndef SYNTH
    // a closing sample always leaves a summary in the queue
    a_scan_end_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_scan_end) |=> (q_count != '0))
        else $error("scan summary lost at queue entry");

    // a queued summary moves to a free output register
    a_back_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count != '0 && empty) |=> !empty)
        else $error("back stage failed to take a waiting summary");

    // queue occupancy stays within its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= (lss_pkg::QUEUE_AW + 1)'(lss_pkg::QUEUE_DEPTH))
        else $error("summary queue overflow");
`endif

endmodule

// File: sim/tb_lidar_sector_steering.sv
// ----------------------------------------------------------------------------
// tb_lidar_sector_steering
// self-checking bench for the lidar sector steering block: samples are pushed
// with random gaps, commands popped with random stalls, and every command is
// compared field by field against a cycle-free model of the scan decision
// ----------------------------------------------------------------------------

// tracks scan state and register values, queues the commands that must come out
class steering_predictor;

    typedef struct packed {
        logic [lss_pkg::CMD_W-1:0]   command;
        logic [lss_pkg::SPEED_W-1:0] left_speed;
        logic [lss_pkg::SPEED_W-1:0] right_speed;
    } t_drive_cmd;

    lss_pkg::t_cfg                  regs;
    logic [lss_pkg::CFG_IDX_W-1:0]  scan_pos;
    logic                           right_blocked;
    logic                           left_blocked;
    logic [lss_pkg::EDGE_W-1:0]     right_edge;
    logic [lss_pkg::EDGE_W-1:0]     left_edge;
    t_drive_cmd                     expected_cmds[$];
    int                             error_count;
    int                             checked;

    function new();
        regs.near_threshold_mm = 16'd1500;
        regs.gap_threshold_mm  = 16'd150;
        regs.right_start_index = 11'd481;
        regs.middle_index      = 11'd642;
        regs.left_end_index    = 11'd803;
        regs.cruise_speed      = 8'd150;
        regs.turn_speed        = 8'd130;
        error_count = 0;
        checked     = 0;
        clear_scan();
    endfunction

    function void clear_scan();
        scan_pos      = '0;
        right_blocked = 1'b0;
        left_blocked  = 1'b0;
        right_edge    = lss_pkg::EDGE_NO_RETURN;
        left_edge     = lss_pkg::EDGE_NO_RETURN;
    endfunction

    function void set_reg(logic [lss_pkg::CFG_ADDR_W-1:0] idx,
                          logic [lss_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lss_pkg::REG_NEAR_THRESHOLD: regs.near_threshold_mm = data;
            lss_pkg::REG_GAP_THRESHOLD:  regs.gap_threshold_mm  = data;
            lss_pkg::REG_RIGHT_START:    regs.right_start_index = data[lss_pkg::CFG_IDX_W-1:0];
            lss_pkg::REG_MIDDLE:         regs.middle_index      = data[lss_pkg::CFG_IDX_W-1:0];
            lss_pkg::REG_LEFT_END:       regs.left_end_index    = data[lss_pkg::CFG_IDX_W-1:0];
            lss_pkg::REG_CRUISE_SPEED:   regs.cruise_speed      = data[lss_pkg::SPEED_W-1:0];
            lss_pkg::REG_TURN_SPEED:     regs.turn_speed        = data[lss_pkg::SPEED_W-1:0];
            default: ;
        endcase
    endfunction

    function void note_sample(logic [lss_pkg::RANGE_W-1:0] range_mm, logic no_return,
                              logic scan_end);
        t_drive_cmd                  cmd;
        logic [lss_pkg::RANGE_W-1:0] gap;
        if (scan_pos >= regs.right_start_index && scan_pos <= regs.left_end_index &&
            !no_return && range_mm < regs.near_threshold_mm) begin
            if (scan_pos <= regs.middle_index)
                right_blocked = 1'b1;
            else
                left_blocked = 1'b1;
        end
        if (scan_pos == regs.right_start_index)
            right_edge = no_return ? lss_pkg::EDGE_NO_RETURN : {1'b0, range_mm};
        if (scan_pos == regs.left_end_index)
            left_edge = no_return ? lss_pkg::EDGE_NO_RETURN : {1'b0, range_mm};
        scan_pos = scan_pos + 1'b1;
        if (!scan_end)
            return;

        cmd.command = lss_pkg::CMD_FORWARD;
        if (right_blocked && left_blocked) begin
            cmd.command = lss_pkg::CMD_STOP;
        end else if (right_blocked) begin
            cmd.command = lss_pkg::CMD_TURN_LEFT;
        end else if (left_blocked) begin
            cmd.command = lss_pkg::CMD_TURN_RIGHT;
        end else if (!right_edge[lss_pkg::RANGE_W] && !left_edge[lss_pkg::RANGE_W]) begin
            gap = (left_edge > right_edge) ?
                  left_edge[lss_pkg::RANGE_W-1:0] - right_edge[lss_pkg::RANGE_W-1:0] :
                  right_edge[lss_pkg::RANGE_W-1:0] - left_edge[lss_pkg::RANGE_W-1:0];
            if (gap > regs.gap_threshold_mm)
                cmd.command = (right_edge > left_edge) ? lss_pkg::CMD_FORWARD_RIGHT
                                                       : lss_pkg::CMD_FORWARD_LEFT;
        end

        case (cmd.command)
            lss_pkg::CMD_STOP: begin
                cmd.left_speed  = '0;
                cmd.right_speed = '0;
            end
            lss_pkg::CMD_TURN_LEFT, lss_pkg::CMD_TURN_RIGHT: begin
                cmd.left_speed  = regs.turn_speed;
                cmd.right_speed = regs.turn_speed;
            end
            lss_pkg::CMD_FORWARD_LEFT: begin
                cmd.left_speed  = regs.turn_speed;
                cmd.right_speed = regs.cruise_speed;
            end
            lss_pkg::CMD_FORWARD_RIGHT: begin
                cmd.left_speed  = regs.cruise_speed;
                cmd.right_speed = regs.turn_speed;
            end
            default: begin
                cmd.left_speed  = regs.cruise_speed;
                cmd.right_speed = regs.cruise_speed;
            end
        endcase
        expected_cmds.push_back(cmd);
        clear_scan();
    endfunction

    task flag_error(string msg);
        error_count++;
        $display("error: command %0d: %s", checked, msg);
    endtask

    task check_command(logic [lss_pkg::CMD_W-1:0] command,
                       logic [lss_pkg::SPEED_W-1:0] left_speed,
                       logic [lss_pkg::SPEED_W-1:0] right_speed);
        t_drive_cmd want;
        checked++;
        if (expected_cmds.size() == 0) begin
            flag_error($sformatf("unexpected command %0d", command));
            return;
        end
        want = expected_cmds.pop_front();
        if (command !== want.command)
            flag_error($sformatf("command %0d, want %0d", command, want.command));
        if (left_speed !== want.left_speed)
            flag_error($sformatf("left speed %0d, want %0d", left_speed, want.left_speed));
        if (right_speed !== want.right_speed)
            flag_error($sformatf("right speed %0d, want %0d", right_speed, want.right_speed));
    endtask

endclass

module tb_lidar_sector_steering;
    timeunit 1ns;
    timeprecision 1ps;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           push          = 1'b0;
    logic                           full;
    logic [lss_pkg::RANGE_W-1:0]    i_range_mm    = '0;
    logic                           i_no_return   = 1'b0;
    logic                           i_scan_end    = 1'b0;
    logic                           empty;
    logic                           pop           = 1'b0;
    logic [lss_pkg::CMD_W-1:0]      o_command;
    logic [lss_pkg::SPEED_W-1:0]    o_left_speed;
    logic [lss_pkg::SPEED_W-1:0]    o_right_speed;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [lss_pkg::CFG_ADDR_W-1:0] i_cfg_index   = '0;
    logic [lss_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;

    // upper bounds of the per-transaction idle draw on each side, 0 gives a burst
    int push_gap_max  = 10;
    int pop_stall_max = 10;

    steering_predictor steer_sb = new();

    lidar_sector_steering dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_range_mm    (i_range_mm),
        .i_no_return   (i_no_return),
        .i_scan_end    (i_scan_end),
        .empty         (empty),
        .pop           (pop),
        .o_command     (o_command),
        .o_left_speed  (o_left_speed),
        .o_right_speed (o_right_speed),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 0;
    end

    // watch both queue ports; values read here are the ones held before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                steer_sb.note_sample(i_range_mm, i_no_return, i_scan_end);
            if (pop && !empty)
                steer_sb.check_command(o_command, o_left_speed, o_right_speed);
        end
    end

    // result side: random stall before each pop transaction, then hold pop until taken
    initial begin
        int stall;
        repeat (6) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, pop_stall_max);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // one sample transaction; push stays high across back-to-back samples
    task automatic send_sample(input logic [lss_pkg::RANGE_W-1:0] range_mm,
                               input logic no_return, input logic scan_end);
        int gap;
        gap = $urandom_range(0, push_gap_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_range_mm  <= range_mm;
        i_no_return <= no_return;
        i_scan_end  <= scan_end;
        do @(posedge i_clk); while (full);
    endtask

    // three-sample scan for the small directed window at indexes 1..2
    task automatic send_trio(input logic [lss_pkg::RANGE_W-1:0] r0,
                             input logic [lss_pkg::RANGE_W-1:0] r1, input logic nr1,
                             input logic [lss_pkg::RANGE_W-1:0] r2, input logic nr2);
        send_sample(r0, 1'b0, 1'b0);
        send_sample(r1, nr1, 1'b0);
        send_sample(r2, nr2, 1'b1);
    endtask

    // wait out all pending commands, then let the pipeline empty
    task automatic settle();
        push <= 1'b0;
        while (steer_sb.expected_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // valid stays high over the burst, dropped once at the end
    task automatic write_reg(input logic [lss_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [lss_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        steer_sb.set_reg(idx, data);
    endtask

    task automatic write_config(input lss_pkg::t_cfg c);
        write_reg(lss_pkg::REG_NEAR_THRESHOLD, c.near_threshold_mm);
        write_reg(lss_pkg::REG_GAP_THRESHOLD,  c.gap_threshold_mm);
        write_reg(lss_pkg::REG_RIGHT_START,
                  (lss_pkg::CFG_DATA_W)'(c.right_start_index));
        write_reg(lss_pkg::REG_MIDDLE,       (lss_pkg::CFG_DATA_W)'(c.middle_index));
        write_reg(lss_pkg::REG_LEFT_END,     (lss_pkg::CFG_DATA_W)'(c.left_end_index));
        write_reg(lss_pkg::REG_CRUISE_SPEED, (lss_pkg::CFG_DATA_W)'(c.cruise_speed));
        write_reg(lss_pkg::REG_TURN_SPEED,   (lss_pkg::CFG_DATA_W)'(c.turn_speed));
        i_cfg_valid <= 1'b0;
    endtask

    // ranges cluster around the near threshold so both sides of the compare show up;
    // spread controls how far apart the edge ranges can be
    function automatic logic [lss_pkg::RANGE_W-1:0] pick_range(int near_pct, int spread);
        int thr;
        int v;
        thr = steer_sb.regs.near_threshold_mm;
        if ($urandom_range(0, 9) == 0)
            return (lss_pkg::RANGE_W)'($urandom);
        if ($urandom_range(0, 99) < near_pct && thr > 0)
            return (lss_pkg::RANGE_W)'($urandom_range(0, thr - 1));
        v = thr + $urandom_range(0, spread);
        return (v > 65535) ? 16'hFFFF : (lss_pkg::RANGE_W)'(v);
    endfunction

    // random scan content; obstacle density, edge spread and dropout rate per scan
    task automatic send_scan(input int len);
        int near_pct;
        int spread;
        int noret_pct;
        case ($urandom_range(0, 4))
            0, 1: near_pct = 0;
            2:    near_pct = 5;
            3:    near_pct = 20;
            default: near_pct = 60;
        endcase
        case ($urandom_range(0, 2))
            0: spread = 0;
            1: spread = 300;
            default: spread = 65535;
        endcase
        case ($urandom_range(0, 2))
            0: noret_pct = 0;
            1: noret_pct = 10;
            default: noret_pct = 30;
        endcase
        for (int i = 0; i < len; i++)
            send_sample(pick_range(near_pct, spread), $urandom_range(0, 99) < noret_pct,
                        i == len - 1);
    endtask

    // small windows keep scans short; sometimes empty, middle anywhere around it
    function automatic lss_pkg::t_cfg random_cfg();
        lss_pkg::t_cfg c;
        case ($urandom_range(0, 4))
            0: c.near_threshold_mm = '0;
            1: c.near_threshold_mm = '1;
            2: c.near_threshold_mm = (lss_pkg::RANGE_W)'($urandom_range(500, 3000));
            default: c.near_threshold_mm = (lss_pkg::RANGE_W)'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: c.gap_threshold_mm = '0;
            1: c.gap_threshold_mm = '1;
            2, 3: c.gap_threshold_mm = (lss_pkg::RANGE_W)'($urandom_range(0, 400));
            default: c.gap_threshold_mm = (lss_pkg::RANGE_W)'($urandom);
        endcase
        c.right_start_index = (lss_pkg::CFG_IDX_W)'($urandom_range(0, 10));
        if ($urandom_range(0, 5) == 0 && c.right_start_index > 0)
            c.left_end_index = (lss_pkg::CFG_IDX_W)'($urandom_range(0,
                                                     c.right_start_index - 1));
        else
            c.left_end_index = c.right_start_index +
                               (lss_pkg::CFG_IDX_W)'($urandom_range(0, 10));
        c.middle_index = (lss_pkg::CFG_IDX_W)'($urandom_range(0, c.left_end_index + 2));
        case ($urandom_range(0, 3))
            0: c.cruise_speed = '0;
            1: c.cruise_speed = '1;
            default: c.cruise_speed = (lss_pkg::SPEED_W)'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: c.turn_speed = '0;
            1: c.turn_speed = '1;
            default: c.turn_speed = (lss_pkg::SPEED_W)'($urandom);
        endcase
        return c;
    endfunction

    initial begin
        lss_pkg::t_cfg c;
        int            n_random;
        int            span;
        int            len;
        n_random = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: last right-half index just under the near threshold,
        // first left one exactly at it
        for (int i = 0; i < 644; i++)
            send_sample((i == 642) ? 16'd1499 : (i == 643) ? 16'd1500 : 16'd5000,
                        1'b0, i == 643);
        settle();

        // directed: window is indexes 1..2, index 1 is the right half
        c.near_threshold_mm = 16'd1000;
        c.gap_threshold_mm  = 16'd100;
        c.right_start_index = 11'd1;
        c.middle_index      = 11'd1;
        c.left_end_index    = 11'd2;
        c.cruise_speed      = 8'd200;
        c.turn_speed        = 8'd50;
        write_config(c);
        send_sample(16'd500, 1'b0, 1'b1);                 // scan ends before either edge
        send_trio(16'd0, 16'd3000, 1'b0, 16'd2000, 1'b0); // near sample outside window, right farther
        send_trio(16'd9000, 16'd2000, 1'b0, 16'd2101, 1'b0); // gap one above threshold
        send_trio(16'd9000, 16'd2000, 1'b0, 16'd2100, 1'b0); // gap equal to threshold
        send_trio(16'd9000, 16'd999, 1'b0, 16'hFFFF, 1'b0);  // right obstacle
        send_trio(16'd9000, 16'd1000, 1'b0, 16'd0, 1'b0);    // left obstacle only
        send_trio(16'd9000, 16'd0, 1'b1, 16'd0, 1'b1);       // no-return samples, no steering
        send_trio(16'd9000, 16'd0, 1'b0, 16'd999, 1'b0);     // both sides blocked
        settle();

        // random phases: fresh registers each time
        while (n_random < 220) begin
            c = random_cfg();
            write_config(c);
            repeat ($urandom_range(3, 8)) begin
                span = (c.left_end_index > c.right_start_index) ? int'(c.left_end_index)
                                                                : int'(c.right_start_index);
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span + 1)
                                                  : span + 1 + $urandom_range(0, 4);
                send_scan(len);
                n_random += len;
            end
            settle();
        end

        // drain, then give stray results a chance to show
        settle();
        repeat (6) @(posedge i_clk);
        if (steer_sb.error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(10_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
design/lss_pkg.sv
design/lss_front.sv
design/lss_queue.sv
design/lss_back.sv
design/lidar_sector_steering.sv
sim/tb_lidar_sector_steering.sv
